// ===== rtl/dtd_pkg.sv =====
`timescale 1ns / 1ps

package dtd_pkg;

    // Parser limits
    localparam int MAX_SIG_DIGITS_DEF = 16;
    localparam int ACC_W              = 64;
    localparam int SCALE_W            = 20;
    localparam int EXPV_W             = 20;

    // Power-of-ten table range
    localparam int K_MIN     = -323;
    localparam int K_MAX     = 308;
    localparam int ROM_DEPTH = K_MAX - K_MIN + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    // Queue between parser and multiplier
    localparam int Q_DEPTH = 2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // One parsed number handed to the back end
    typedef struct packed {
        logic [1:0]        status;
        logic              neg;
        logic [ACC_W-1:0]  acc;
        logic [ROM_AW-1:0] rom_idx;
    } dtd_job_t;

    // Correctly rounded 10^k, k = K_MIN..K_MAX, as binary64 bit patterns
    localparam logic [63:0] POW10_ROM [0:ROM_DEPTH-1] = '{
        64'h0000000000000002, 64'h0000000000000014, 64'h00000000000000CA, 64'h00000000000007E8,
        64'h0000000000004F10, 64'h00000000000316A2, 64'h00000000001EE257, 64'h000000000134D761,
        64'h000000000C1069CD, 64'h0000000078A42205, 64'h00000004B6695433, 64'h0000002F201D49FB,
        64'h000001D74124E3D1, 64'h000012688B70E62B, 64'h0000B8157268FDAF, 64'h000730D67819E8D2,
        64'h0031FA182C40C60D, 64'h0066789E3750F791, 64'h009C16C5C5253575, 64'h00D18E3B9B374169,
        64'h0105F1CA820511C3, 64'h013B6E3D22865634, 64'h017124E63593F5E1, 64'h01A56E1FC2F8F359,
        64'h01DAC9A7B3B7302F, 64'h0210BE08D0527E1D, 64'h0244ED8B04671DA5, 64'h027A28EDC580E50E,
        64'h02B059949B708F29, 64'h02E46FF9C24CB2F3, 64'h03198BF832DFDFB0, 64'h034FEEF63F97D79C,
        64'h0383F559E7BEE6C1, 64'h03B8F2B061AEA072, 64'h03EF2F5C7A1A488E, 64'h04237D99CC506D59,
        64'h04585D003F6488AF, 64'h048E74404F3DAADB, 64'h04C308A831868AC9, 64'h04F7CAD23DE82D7B,
        64'h052DBD86CD6238D9, 64'h05629674405D6388, 64'h05973C115074BC6A, 64'h05CD0B15A491EB84,
        64'h060226ED86DB3333, 64'h0636B0A8E891FFFF, 64'h066C5CD322B67FFF, 64'h06A1BA03F5B21000,
        64'h06D62884F31E93FF, 64'h070BB2A62FE638FF, 64'h07414FA7DDEFE3A0, 64'h0775A391D56BDC87,
        64'h07AB0C764AC6D3A9, 64'h07E0E7C9EEBC444A, 64'h081521BC6A6B555C, 64'h084A6A2B85062AB3,
        64'h0880825B3323DAB0, 64'h08B4A2F1FFECD15C, 64'h08E9CBAE7FE805B3, 64'h09201F4D0FF10390,
        64'h0954272053ED4474, 64'h098930E868E89591, 64'h09BF7D228322BAF5, 64'h09F3AE3591F5B4D9,
        64'h0A2899C2F6732210, 64'h0A5EC033B40FEA93, 64'h0A9338205089F29C, 64'h0AC8062864AC6F43,
        64'h0AFE07B27DD78B14, 64'h0B32C4CF8EA6B6EC, 64'h0B677603725064A8, 64'h0B9D53844EE47DD1,
        64'h0BD25432B14ECEA3, 64'h0C06E93F5DA2824C, 64'h0C3CA38F350B22DF, 64'h0C71E6398126F5CB,
        64'h0CA65FC7E170B33E, 64'h0CDBF7B9D9CCE00D, 64'h0D117AD428200C08, 64'h0D45D98932280F0A,
        64'h0D7B4FEB7EB212CD, 64'h0DB111F32F2F4BC0, 64'h0DE5566FFAFB1EB0, 64'h0E1AAC0BF9B9E65C,
        64'h0E50AB877C142FFA, 64'h0E84D6695B193BF8, 64'h0EBA0C03B1DF8AF6, 64'h0EF047824F2BB6DA,
        64'h0F245962E2F6A490, 64'h0F596FBB9BB44DB4, 64'h0F8FCBAA82A16121, 64'h0FC3DF4A91A4DCB5,
        64'h0FF8D71D360E13E2, 64'h102F0CE4839198DB, 64'h1063680ED23AFF89, 64'h1098421286C9BF6B,
        64'h10CE5297287C2F45, 64'h1102F39E794D9D8B, 64'h1137B08617A104EE, 64'h116D9CA79D89462A,
        64'h11A281E8C275CBDA, 64'h11D72262F3133ED1, 64'h120CEAFBAFD80E85, 64'h124212DD4DE70913,
        64'h12769794A160CB58, 64'h12AC3D79C9B8FE2E, 64'h12E1A66C1E139EDD, 64'h1316100725988694,
        64'h134B9408EEFEA839, 64'h13813C85955F2923, 64'h13B58BA6FAB6F36C, 64'h13EAEE90B964B047,
        64'h1420D51A73DEEE2D, 64'h14550A6110D6A9B8, 64'h148A4CF9550C5426, 64'h14C0701BD527B498,
        64'h14F48C22CA71A1BD, 64'h1529AF2B7D0E0A2D, 64'h15600D7B2E28C65C, 64'h159410D9F9B2F7F3,
        64'h15C91510781FB5F0, 64'h15FF5A549627A36C, 64'h16339874DDD8C623, 64'h16687E92154EF7AC,
        64'h169E9E369AA2B597, 64'h16D322E220A5B17E, 64'h1707EB9AA8CF1DDE, 64'h173DE6815302E556,
        64'h1772B010D3E1CF56, 64'h17A75C1508DA432B, 64'h17DD331A4B10D3F6, 64'h18123FF06EEA847A,
        64'h1846CFEC8AA52598, 64'h187C83E7AD4E6EFE, 64'h18B1D270CC51055F, 64'h18E6470CFF6546B6,
        64'h191BD8D03F3E9864, 64'h1951678227871F3E, 64'h1985C162B168E70E, 64'h19BB31BB5DC320D2,
        64'h19F0FF151A99F483, 64'h1A253EDA614071A4, 64'h1A5A8E90F9908E0D, 64'h1A90991A9BFA58C8,
        64'h1AC4BF6142F8EEFA, 64'h1AF9EF3993B72AB8, 64'h1B303583FC527AB3, 64'h1B6442E4FB671960,
        64'h1B99539E3A40DFB8, 64'h1BCFA885C8D117A6, 64'h1C03C9539D82AEC8, 64'h1C38BBA884E35A7A,
        64'h1C6EEA92A61C3118, 64'h1CA3529BA7D19EAF, 64'h1CD8274291C6065B, 64'h1D0E3113363787F2,
        64'h1D42DEAC01E2B4F7, 64'h1D779657025B6235, 64'h1DAD7BECC2F23AC2, 64'h1DE26D73F9D764B9,
        64'h1E1708D0F84D3DE7, 64'h1E4CCB0536608D61, 64'h1E81FEE341FC585D, 64'h1EB67E9C127B6E74,
        64'h1EEC1E43171A4A11, 64'h1F2192E9EE706E4B, 64'h1F55F7A46A0C89DD, 64'h1F8B758D848FAC55,
        64'h1FC1297872D9CBB5, 64'h1FF573D68F903EA2, 64'h202AD0CC33744E4B, 64'h2060C27FA028B0EF,
        64'h2094F31F8832DD2A, 64'h20CA2FE76A3F9475, 64'h21005DF0A267BCC9, 64'h2134756CCB01ABFB,
        64'h216992C7FDC216FA, 64'h219FF779FD329CB9, 64'h21D3FAAC3E3FA1F3, 64'h2208F9574DCF8A70,
        64'h223F37AD21436D0C, 64'h227382CC34CA2428, 64'h22A8637F41FCAD32, 64'h22DE7C5F127BD87E,
        64'h23130DBB6B8D674F, 64'h2347D12A4670C123, 64'h237DC574D80CF16B, 64'h23B29B69070816E3,
        64'h23E7424348CA1C9C, 64'h241D12D41AFCA3C3, 64'h24522BC490DDE65A, 64'h2486B6B5B5155FF0,
        64'h24BC6463225AB7EC, 64'h24F1BEBDF578B2F4, 64'h25262E6D72D6DFB0, 64'h255BBA08CF8C979D,
        64'h2591544581B7DEC2, 64'h25C5A956E225D672, 64'h25FB13AC9AAF4C0F, 64'h2630EC4BE0AD8F89,
        64'h2665275ED8D8F36C, 64'h269A71368F0F3047, 64'h26D086C219697E2C, 64'h2704A8729FC3DDB7,
        64'h2739D28F47B4D525, 64'h277023998CD10537, 64'h27A42C7FF0054685, 64'h27D9379FEC069826,
        64'h280F8587E7083E30, 64'h2843B374F06526DE, 64'h2878A0522C7E7095, 64'h28AEC866B79E0CBA,
        64'h28E33D4032C2C7F5, 64'h29180C903F7379F2, 64'h294E0FB44F50586E, 64'h2982C9D0B1923745,
        64'h29B77C44DDF6C516, 64'h29ED5B561574765B, 64'h2A225915CD68C9F9, 64'h2A56EF5B40C2FC77,
        64'h2A8CAB3210F3BB95, 64'h2AC1EAFF4A98553D, 64'h2AF665BF1D3E6A8D, 64'h2B2BFF2EE48E0530,
        64'h2B617F7D4ED8C33E, 64'h2B95DF5CA28EF40D, 64'h2BCB5733CB32B111, 64'h2C0116805EFFAEAA,
        64'h2C355C2076BF9A55, 64'h2C6AB328946F80EA, 64'h2CA0AFF95CC5B092, 64'h2CD4DBF7B3F71CB7,
        64'h2D0A12F5A0F4E3E5, 64'h2D404BD984990E6F, 64'h2D745ECFE5BF520B, 64'h2DA97683DF2F268D,
        64'h2DDFD424D6FAF031, 64'h2E13E497065CD61F, 64'h2E48DDBCC7F40BA6, 64'h2E7F152BF9F10E90,
        64'h2EB36D3B7C36A91A, 64'h2EE8488A5B445360, 64'h2F1E5AACF2156838, 64'h2F52F8AC174D6123,
        64'h2F87B6D71D20B96C, 64'h2FBDA48CE468E7C7, 64'h2FF286D80EC190DC, 64'h3027288E1271F513,
        64'h305CF2B1970E7258, 64'h309217AEFE690777, 64'h30C69D9ABE034955, 64'h30FC45016D841BAA,
        64'h3131AB20E472914A, 64'h316615E91D8F359D, 64'h319B9B6364F30304, 64'h31D1411E1F17E1E3,
        64'h32059165A6DDDA5B, 64'h323AF5BF109550F2, 64'h3270D9976A5D5297, 64'h32A50FFD44F4A73D,
        64'h32DA53FC9631D10D, 64'h3310747DDDDF22A8, 64'h3344919D5556EB52, 64'h3379B604AAACA626,
        64'h33B011C2EAABE7D8, 64'h33E41633A556E1CE, 64'h34191BC08EAC9A41, 64'h344F62B0B257C0D2,
        64'h34839DAE6F76D883, 64'h34B8851A0B548EA4, 64'h34EEA6608E29B24D, 64'h352327FC58DA0F70,
        64'h3557F1FB6F10934C, 64'h358DEE7A4AD4B81F, 64'h35C2B50C6EC4F313, 64'h35F7624F8A762FD8,
        64'h362D3AE36D13BBCE, 64'h366244CE242C5561, 64'h3696D601AD376AB9, 64'h36CC8B8218854567,
        64'h3701D7314F534B61, 64'h37364CFDA3281E39, 64'h376BE03D0BF225C7, 64'h37A16C262777579C,
        64'h37D5C72FB1552D83, 64'h380B38FB9DAA78E4, 64'h3841039D428A8B8F, 64'h38754484932D2E72,
        64'h38AA95A5B7F87A0F, 64'h38E09D8792FB4C49, 64'h3914C4E977BA1F5C, 64'h3949F623D5A8A733,
        64'h398039D665896880, 64'h39B4484BFEEBC2A0, 64'h39E95A5EFEA6B347, 64'h3A1FB0F6BE506019,
        64'h3A53CE9A36F23C10, 64'h3A88C240C4AECB14, 64'h3ABEF2D0F5DA7DD9, 64'h3AF357C299A88EA7,
        64'h3B282DB34012B251, 64'h3B5E392010175EE6, 64'h3B92E3B40A0E9B4F, 64'h3BC79CA10C924223,
        64'h3BFD83C94FB6D2AC, 64'h3C32725DD1D243AC, 64'h3C670EF54646D497, 64'h3C9CD2B297D889BC,
        64'h3CD203AF9EE75616, 64'h3D06849B86A12B9B, 64'h3D3C25C268497682, 64'h3D719799812DEA11,
        64'h3DA5FD7FE1796495, 64'h3DDB7CDFD9D7BDBB, 64'h3E112E0BE826D695, 64'h3E45798EE2308C3A,
        64'h3E7AD7F29ABCAF48, 64'h3EB0C6F7A0B5ED8D, 64'h3EE4F8B588E368F1, 64'h3F1A36E2EB1C432D,
        64'h3F50624DD2F1A9FC, 64'h3F847AE147AE147B, 64'h3FB999999999999A, 64'h3FF0000000000000,
        64'h4024000000000000, 64'h4059000000000000, 64'h408F400000000000, 64'h40C3880000000000,
        64'h40F86A0000000000, 64'h412E848000000000, 64'h416312D000000000, 64'h4197D78400000000,
        64'h41CDCD6500000000, 64'h4202A05F20000000, 64'h42374876E8000000, 64'h426D1A94A2000000,
        64'h42A2309CE5400000, 64'h42D6BCC41E900000, 64'h430C6BF526340000, 64'h4341C37937E08000,
        64'h4376345785D8A000, 64'h43ABC16D674EC800, 64'h43E158E460913D00, 64'h4415AF1D78B58C40,
        64'h444B1AE4D6E2EF50, 64'h4480F0CF064DD592, 64'h44B52D02C7E14AF6, 64'h44EA784379D99DB4,
        64'h45208B2A2C280291, 64'h4554ADF4B7320335, 64'h4589D971E4FE8402, 64'h45C027E72F1F1281,
        64'h45F431E0FAE6D721, 64'h46293E5939A08CEA, 64'h465F8DEF8808B024, 64'h4693B8B5B5056E17,
        64'h46C8A6E32246C99C, 64'h46FED09BEAD87C03, 64'h4733426172C74D82, 64'h476812F9CF7920E3,
        64'h479E17B84357691B, 64'h47D2CED32A16A1B1, 64'h48078287F49C4A1D, 64'h483D6329F1C35CA5,
        64'h48725DFA371A19E7, 64'h48A6F578C4E0A061, 64'h48DCB2D6F618C879, 64'h4911EFC659CF7D4C,
        64'h49466BB7F0435C9E, 64'h497C06A5EC5433C6, 64'h49B18427B3B4A05C, 64'h49E5E531A0A1C873,
        64'h4A1B5E7E08CA3A8F, 64'h4A511B0EC57E649A, 64'h4A8561D276DDFDC0, 64'h4ABABA4714957D30,
        64'h4AF0B46C6CDD6E3E, 64'h4B24E1878814C9CE, 64'h4B5A19E96A19FC41, 64'h4B905031E2503DA9,
        64'h4BC4643E5AE44D13, 64'h4BF97D4DF19D6057, 64'h4C2FDCA16E04B86D, 64'h4C63E9E4E4C2F344,
        64'h4C98E45E1DF3B015, 64'h4CCF1D75A5709C1B, 64'h4D03726987666191, 64'h4D384F03E93FF9F5,
        64'h4D6E62C4E38FF872, 64'h4DA2FDBB0E39FB47, 64'h4DD7BD29D1C87A19, 64'h4E0DAC74463A989F,
        64'h4E428BC8ABE49F64, 64'h4E772EBAD6DDC73D, 64'h4EACFA698C95390C, 64'h4EE21C81F7DD43A7,
        64'h4F16A3A275D49491, 64'h4F4C4C8B1349B9B5, 64'h4F81AFD6EC0E1411, 64'h4FB61BCCA7119916,
        64'h4FEBA2BFD0D5FF5B, 64'h502145B7E285BF99, 64'h50559725DB272F7F, 64'h508AFCEF51F0FB5F,
        64'h50C0DE1593369D1B, 64'h50F5159AF8044462, 64'h512A5B01B605557B, 64'h516078E111C3556D,
        64'h5194971956342AC8, 64'h51C9BCDFABC1357A, 64'h5200160BCB58C16C, 64'h52341B8EBE2EF1C7,
        64'h526922726DBAAE39, 64'h529F6B0F092959C7, 64'h52D3A2E965B9D81D, 64'h53088BA3BF284E24,
        64'h533EAE8CAEF261AD, 64'h53732D17ED577D0C, 64'h53A7F85DE8AD5C4F, 64'h53DDF67562D8B363,
        64'h5412BA095DC7701E, 64'h5447688BB5394C25, 64'h547D42AEA2879F2E, 64'h54B249AD2594C37D,
        64'h54E6DC186EF9F45C, 64'h551C931E8AB87173, 64'h5551DBF316B346E8, 64'h558652EFDC6018A2,
        64'h55BBE7ABD3781ECA, 64'h55F170CB642B133F, 64'h5625CCFE3D35D80E, 64'h565B403DCC834E12,
        64'h569108269FD210CB, 64'h56C54A3047C694FE, 64'h56FA9CBC59B83A3D, 64'h5730A1F5B8132466,
        64'h5764CA732617ED80, 64'h5799FD0FEF9DE8E0, 64'h57D03E29F5C2B18C, 64'h58044DB473335DEF,
        64'h583961219000356B, 64'h586FB969F40042C5, 64'h58A3D3E2388029BB, 64'h58D8C8DAC6A0342A,
        64'h590EFB1178484135, 64'h59435CEAEB2D28C1, 64'h59783425A5F872F1, 64'h59AE412F0F768FAD,
        64'h59E2E8BD69AA19CC, 64'h5A17A2ECC414A03F, 64'h5A4D8BA7F519C84F, 64'h5A827748F9301D32,
        64'h5AB7151B377C247E, 64'h5AECDA62055B2D9E, 64'h5B22087D4358FC82, 64'h5B568A9C942F3BA3,
        64'h5B8C2D43B93B0A8C, 64'h5BC19C4A53C4E697, 64'h5BF6035CE8B6203D, 64'h5C2B843422E3A84D,
        64'h5C6132A095CE4930, 64'h5C957F48BB41DB7C, 64'h5CCADF1AEA12525B, 64'h5D00CB70D24B7379,
        64'h5D34FE4D06DE5057, 64'h5D6A3DE04895E46D, 64'h5DA066AC2D5DAEC4, 64'h5DD4805738B51A75,
        64'h5E09A06D06E26112, 64'h5E400444244D7CAB, 64'h5E7405552D60DBD6, 64'h5EA906AA78B912CC,
        64'h5EDF485516E7577F, 64'h5F138D352E5096AF, 64'h5F48708279E4BC5B, 64'h5F7E8CA3185DEB72,
        64'h5FB317E5EF3AB327, 64'h5FE7DDDF6B095FF1, 64'h601DD55745CBB7ED, 64'h6052A5568B9F52F4,
        64'h60874EAC2E8727B1, 64'h60BD22573A28F19D, 64'h60F2357684599702, 64'h6126C2D4256FFCC3,
        64'h615C73892ECBFBF4, 64'h6191C835BD3F7D78, 64'h61C63A432C8F5CD6, 64'h61FBC8D3F7B3340C,
        64'h62315D847AD00087, 64'h6265B4E5998400A9, 64'h629B221EFFE500D4, 64'h62D0F5535FEF2084,
        64'h630532A837EAE8A5, 64'h633A7F5245E5A2CF, 64'h63708F936BAF85C1, 64'h63A4B378469B6732,
        64'h63D9E056584240FE, 64'h64102C35F729689F, 64'h6444374374F3C2C6, 64'h647945145230B378,
        64'h64AF965966BCE056, 64'h64E3BDF7E0360C36, 64'h6518AD75D8438F43, 64'h654ED8D34E547314,
        64'h6583478410F4C7EC, 64'h65B819651531F9E8, 64'h65EE1FBE5A7E7861, 64'h6622D3D6F88F0B3D,
        64'h665788CCB6B2CE0C, 64'h668D6AFFE45F818F, 64'h66C262DFEEBBB0F9, 64'h66F6FB97EA6A9D38,
        64'h672CBA7DE5054486, 64'h6761F48EAF234AD4, 64'h679671B25AEC1D89, 64'h67CC0E1EF1A724EB,
        64'h680188D357087713, 64'h6835EB082CCA94D7, 64'h686B65CA37FD3A0D, 64'h68A11F9E62FE4448,
        64'h68D56785FBBDD55A, 64'h690AC1677AAD4AB1, 64'h6940B8E0ACAC4EAF, 64'h6974E718D7D7625A,
        64'h69AA20DF0DCD3AF1, 64'h69E0548B68A044D6, 64'h6A1469AE42C8560C, 64'h6A498419D37A6B8F,
        64'h6A7FE52048590673, 64'h6AB3EF342D37A408, 64'h6AE8EB0138858D0A, 64'h6B1F25C186A6F04C,
        64'h6B537798F4285630, 64'h6B88557F31326BBB, 64'h6BBE6ADEFD7F06AA, 64'h6BF302CB5E6F642A,
        64'h6C27C37E360B3D35, 64'h6C5DB45DC38E0C82, 64'h6C9290BA9A38C7D1, 64'h6CC734E940C6F9C6,
        64'h6CFD022390F8B837, 64'h6D3221563A9B7323, 64'h6D66A9ABC9424FEB, 64'h6D9C5416BB92E3E6,
        64'h6DD1B48E353BCE70, 64'h6E0621B1C28AC20C, 64'h6E3BAA1E332D728F, 64'h6E714A52DFFC6799,
        64'h6EA59CE797FB817F, 64'h6EDB04217DFA61DF, 64'h6F10E294EEBC7D2C, 64'h6F451B3A2A6B9C76,
        64'h6F7A6208B5068394, 64'h6FB07D457124123D, 64'h6FE49C96CD6D16CC, 64'h7019C3BC80C85C7F,
        64'h70501A55D07D39CF, 64'h708420EB449C8843, 64'h70B9292615C3AA54, 64'h70EF736F9B3494E9,
        64'h7123A825C100DD11, 64'h7158922F31411456, 64'h718EB6BAFD91596B, 64'h71C33234DE7AD7E3,
        64'h71F7FEC216198DDC, 64'h722DFE729B9FF153, 64'h7262BF07A143F6D4, 64'h72976EC98994F489,
        64'h72CD4A7BEBFA31AB, 64'h73024E8D737C5F0B, 64'h7336E230D05B76CD, 64'h736C9ABD04725481,
        64'h73A1E0B622C774D0, 64'h73D658E3AB795204, 64'h740BEF1C9657A686, 64'h74417571DDF6C814,
        64'h7475D2CE55747A18, 64'h74AB4781EAD1989E, 64'h74E10CB132C2FF63, 64'h75154FDD7F73BF3C,
        64'h754AA3D4DF50AF0B, 64'h7580A6650B926D67, 64'h75B4CFFE4E7708C0, 64'h75EA03FDE214CAF1,
        64'h7620427EAD4CFED6, 64'h7654531E58A03E8C, 64'h768967E5EEC84E2F, 64'h76BFC1DF6A7A61BB,
        64'h76F3D92BA28C7D15, 64'h7728CF768B2F9C5A, 64'h775F03542DFB8370, 64'h779362149CBD3226,
        64'h77C83A99C3EC7EB0, 64'h77FE494034E79E5C, 64'h7832EDC82110C2F9, 64'h7867A93A2954F3B8,
        64'h789D9388B3AA30A5, 64'h78D27C35704A5E67, 64'h79071B42CC5CF601, 64'h793CE2137F743382,
        64'h79720D4C2FA8A031, 64'h79A6909F3B92C83D, 64'h79DC34C70A777A4D, 64'h7A11A0FC668AAC70,
        64'h7A46093B802D578C, 64'h7A7B8B8A6038AD6F, 64'h7AB137367C236C65, 64'h7AE585041B2C477F,
        64'h7B1AE64521F7595E, 64'h7B50CFEB353A97DB, 64'h7B8503E602893DD2, 64'h7BBA44DF832B8D46,
        64'h7BF06B0BB1FB384C, 64'h7C2485CE9E7A065F, 64'h7C59A742461887F6, 64'h7C9008896BCF54FA,
        64'h7CC40AABC6C32A38, 64'h7CF90D56B873F4C7, 64'h7D2F50AC6690F1F8, 64'h7D63926BC01A973B,
        64'h7D987706B0213D0A, 64'h7DCE94C85C298C4C, 64'h7E031CFD3999F7B0, 64'h7E37E43C8800759C,
        64'h7E6DDD4BAA009303, 64'h7EA2AA4F4A405BE2, 64'h7ED754E31CD072DA, 64'h7F0D2A1BE4048F90,
        64'h7F423A516E82D9BA, 64'h7F76C8E5CA239029, 64'h7FAC7B1F3CAC7433, 64'h7FE1CCF385EBC8A0
    };

endpackage

// ===== rtl/decimal_text_to_double_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Payload
// input     in         push / full       char_code[7:0], last_char
// result    out        empty / pop       value_bits[63:0], status[1:0]
//
// The parser takes one character per cycle unless full is high; a number
// leaves it on its last character and waits in a two-entry queue for the
// multiplier. The multiplier is a sequencer: mantissa normalize, four
// 27x27 partial products, product normalize, subnormal shifting (one bit
// per cycle) and rounding. Error and zero results bypass the sequencer.
// full rises while the queue holds two numbers; results wait in one output
// register until popped. Reset is asynchronous, active low, and clears
// parser and sequencer.

module decimal_text_to_double_top #(
    parameter int MAX_SIG_DIGITS = dtd_pkg::MAX_SIG_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] value_bits,
    output logic [1:0]  status
);

    logic              in_fire;
    logic              job_push;
    dtd_pkg::dtd_job_t job, q_data;
    logic              q_full, q_empty, q_pop;
    logic              out_valid;

    assign full    = q_full;
    assign in_fire = push && !q_full;
    assign empty   = !out_valid;

    dtd_front #(
        .MAX_SIG_DIGITS (MAX_SIG_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .char_code (char_code),
        .last_char (last_char),
        .job_push  (job_push),
        .job       (job)
    );

    dtd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    dtd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_take   (pop),
        .value_bits (value_bits),
        .status     (status)
    );

endmodule

// ===== rtl/dtd_front.sv =====
`timescale 1ns / 1ps

module dtd_front #(
    parameter int MAX_SIG_DIGITS = dtd_pkg::MAX_SIG_DIGITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       char_code,
    input  logic             last_char,
    output logic             job_push,
    output dtd_pkg::dtd_job_t job
);

    localparam int SL_W = $clog2(MAX_SIG_DIGITS + 1);
    localparam int AW   = dtd_pkg::ACC_W;
    localparam int SW   = dtd_pkg::SCALE_W;
    localparam int EW   = dtd_pkg::EXPV_W;
    localparam int KW   = SW + 3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_E  = 8'h65;

    localparam logic signed [SW-1:0] SCALE_HI = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SCALE_LO = {1'b1, {(SW-1){1'b0}}};
    localparam logic [EW-1:0]        EXP_SAT  = {EW{1'b1}};
    localparam logic [EW-1:0]        EXP_LIM  = EXP_SAT / 10;

    typedef enum logic [3:0] {
        PH_START, PH_AFTER_SIGN, PH_LEAD_INT, PH_LEAD_DEC, PH_SIG_INT, PH_SIG_DEC,
        PH_INSIG_INT, PH_INSIG_DEC, PH_EXP_MARK, PH_EXP_SIGN, PH_EXP_DIG,
        PH_END_CHECK, PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic [AW-1:0]          accz_reg, accz_next;
    logic [SL_W-1:0]        pz_reg, pz_next;
    logic [SL_W-1:0]        sl_reg, sl_next;
    logic signed [SW-1:0]   scale_reg, scale_next;
    logic [EW-1:0]          ev_reg, ev_next;
    logic                   eneg_reg, eneg_next;
    logic                   vneg_reg, vneg_next;
    logic                   err_reg, err_next;

    // Character classes
    logic       ws, mark, dig;
    logic [3:0] d;
    assign ws   = (char_code == CH_SP) || (char_code == CH_TAB);
    assign mark = (char_code == CH_DOT) || (char_code == CH_COMMA);
    assign dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign d    = 4'(char_code - CH_ZERO);

    // Phase walk: one character may fall through several phases
    phase_t ph;
    logic   fin;
    logic   act_neg, act_eneg, act_dn, act_up, act_keep, act_exp, act_err;

    always_comb
    begin
        ph       = phase_reg;
        fin      = 1'b0;
        act_neg  = 1'b0;
        act_eneg = 1'b0;
        act_dn   = 1'b0;
        act_up   = 1'b0;
        act_keep = 1'b0;
        act_exp  = 1'b0;
        act_err  = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!fin)
            begin
                unique case (ph)
                    PH_START:
                    begin
                        if (ws) fin = 1'b1;
                        else if (char_code == CH_MINUS)
                        begin
                            act_neg = 1'b1;
                            ph      = PH_AFTER_SIGN;
                            fin     = 1'b1;
                        end
                        else if (char_code == CH_PLUS)
                        begin
                            ph  = PH_AFTER_SIGN;
                            fin = 1'b1;
                        end
                        else ph = PH_LEAD_INT;
                    end
                    PH_AFTER_SIGN:
                    begin
                        if (ws) fin = 1'b1;
                        else ph = PH_LEAD_INT;
                    end
                    PH_LEAD_INT:
                    begin
                        if (char_code == CH_ZERO) fin = 1'b1;
                        else if (mark)
                        begin
                            ph  = PH_LEAD_DEC;
                            fin = 1'b1;
                        end
                        else ph = PH_SIG_INT;
                    end
                    PH_LEAD_DEC:
                    begin
                        if (char_code == CH_ZERO)
                        begin
                            act_dn = 1'b1;
                            fin    = 1'b1;
                        end
                        else ph = PH_SIG_DEC;
                    end
                    PH_SIG_INT:
                    begin
                        if (dig)
                        begin
                            act_keep = 1'b1;
                            fin      = 1'b1;
                        end
                        else if (mark)
                        begin
                            ph  = PH_SIG_DEC;
                            fin = 1'b1;
                        end
                        else ph = PH_EXP_MARK;
                    end
                    PH_SIG_DEC:
                    begin
                        if (dig)
                        begin
                            act_dn   = 1'b1;
                            act_keep = 1'b1;
                            fin      = 1'b1;
                        end
                        else ph = PH_EXP_MARK;
                    end
                    PH_INSIG_INT:
                    begin
                        if (dig)
                        begin
                            act_up = 1'b1;
                            fin    = 1'b1;
                        end
                        else if (mark)
                        begin
                            ph  = PH_INSIG_DEC;
                            fin = 1'b1;
                        end
                        else ph = PH_EXP_MARK;
                    end
                    PH_INSIG_DEC:
                    begin
                        if (dig) fin = 1'b1;
                        else ph = PH_EXP_MARK;
                    end
                    PH_EXP_MARK:
                    begin
                        if ((char_code == CH_UP_E) || (char_code == CH_LO_E))
                        begin
                            ph  = PH_EXP_SIGN;
                            fin = 1'b1;
                        end
                        else ph = PH_END_CHECK;
                    end
                    PH_EXP_SIGN:
                    begin
                        if (char_code == CH_MINUS)
                        begin
                            act_eneg = 1'b1;
                            ph       = PH_EXP_DIG;
                            fin      = 1'b1;
                        end
                        else if (char_code == CH_PLUS)
                        begin
                            ph  = PH_EXP_DIG;
                            fin = 1'b1;
                        end
                        else ph = PH_EXP_DIG;
                    end
                    PH_EXP_DIG:
                    begin
                        if (dig)
                        begin
                            act_exp = 1'b1;
                            fin     = 1'b1;
                        end
                        else ph = PH_END_CHECK;
                    end
                    PH_END_CHECK:
                    begin
                        act_err = !((char_code == CH_NUL) || ws);
                        ph      = PH_DONE;
                        fin     = 1'b1;
                    end
                    default: fin = 1'b1;
                endcase
            end
        end
    end

    // Datapath updates for the chosen action
    logic [AW-1:0]   accz_x10;
    logic [EW+3:0]   ev_x10;
    logic [EW+3:0]   ev_sum;

    assign accz_x10 = (accz_reg << 3) + (accz_reg << 1);
    assign ev_x10   = ({4'b0, ev_reg} << 3) + ({4'b0, ev_reg} << 1);
    assign ev_sum   = ev_x10 + {{(EW){1'b0}}, d};

    always_comb
    begin
        phase_next = ph;
        acc_next   = acc_reg;
        accz_next  = accz_reg;
        pz_next    = pz_reg;
        sl_next    = sl_reg;
        scale_next = scale_reg;
        ev_next    = ev_reg;
        eneg_next  = eneg_reg | act_eneg;
        vneg_next  = vneg_reg | act_neg;
        err_next   = err_reg | act_err;
        if (act_dn && (scale_reg != SCALE_LO))
            scale_next = scale_reg - 1'b1;
        if (act_up && (scale_reg != SCALE_HI))
            scale_next = scale_reg + 1'b1;
        if (act_exp)
        begin
            if ((ev_reg > EXP_LIM) || (ev_sum > {4'b0, EXP_SAT}))
                ev_next = EXP_SAT;
            else
                ev_next = ev_sum[EW-1:0];
        end
        // Zeros wait in accz so a later nonzero digit needs only one *10
        if (act_keep)
        begin
            if (d != 4'd0)
            begin
                acc_next  = accz_x10 + AW'(d);
                accz_next = accz_x10 + AW'(d);
                pz_next   = '0;
            end
            else
            begin
                accz_next = accz_x10;
                pz_next   = pz_reg + 1'b1;
            end
            sl_next = sl_reg - 1'b1;
            if (sl_reg <= SL_W'(1))
                phase_next = (ph == PH_SIG_INT) ? PH_INSIG_INT : PH_INSIG_DEC;
        end
    end

    // Final decimal scale and status
    logic signed [KW-1:0] ev_term, k;
    always_comb
    begin
        ev_term = signed'({3'b0, ev_next});
        if (eneg_next)
            ev_term = -ev_term;
        k = ev_term + KW'(scale_next) + signed'(KW'(pz_next));

        job.neg     = vneg_next;
        job.acc     = acc_next;
        job.rom_idx = dtd_pkg::ROM_AW'(k - KW'(dtd_pkg::K_MIN));
        if (err_next)
            job.status = dtd_pkg::ST_SYNTAX;
        else if (acc_next == '0)
            job.status = dtd_pkg::ST_OK;
        else if ((k < KW'(dtd_pkg::K_MIN)) || (k > KW'(dtd_pkg::K_MAX)))
            job.status = dtd_pkg::ST_RANGE;
        else
            job.status = dtd_pkg::ST_OK;
    end

    assign job_push = in_fire && last_char;

    // Parser state; cleared after each number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            accz_reg  <= '0;
            pz_reg    <= '0;
            sl_reg    <= SL_W'(MAX_SIG_DIGITS);
            scale_reg <= '0;
            ev_reg    <= '0;
            eneg_reg  <= 1'b0;
            vneg_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            if (last_char)
            begin
                phase_reg <= PH_START;
                acc_reg   <= '0;
                accz_reg  <= '0;
                pz_reg    <= '0;
                sl_reg    <= SL_W'(MAX_SIG_DIGITS);
                scale_reg <= '0;
                ev_reg    <= '0;
                eneg_reg  <= 1'b0;
                vneg_reg  <= 1'b0;
                err_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                accz_reg  <= accz_next;
                pz_reg    <= pz_next;
                sl_reg    <= sl_next;
                scale_reg <= scale_next;
                ev_reg    <= ev_next;
                eneg_reg  <= eneg_next;
                vneg_reg  <= vneg_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ===== rtl/dtd_queue.sv =====
`timescale 1ns / 1ps

module dtd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dtd_pkg::dtd_job_t wr_data,
    input  logic              rd_en,
    output dtd_pkg::dtd_job_t rd_data,
    output logic              full,
    output logic              empty
);

    localparam int DEPTH = dtd_pkg::Q_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    dtd_pkg::dtd_job_t mem [0:DEPTH-1];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [PW:0]       cnt_reg;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/dtd_back.sv =====
`timescale 1ns / 1ps

module dtd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  dtd_pkg::dtd_job_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_take,
    output logic [63:0]       value_bits,
    output logic [1:0]        status
);

    typedef enum logic [2:0] {
        S_IDLE, S_ANORM, S_MUL, S_PNORM, S_DENORM, S_ROUND
    } state_t;

    state_t               state_reg;
    logic [63:0]          a_reg;
    logic [63:0]          rom_reg;
    logic [5:0]           sh_reg;
    logic [52:0]          mx_reg, mp_reg;
    logic [53:0]          prod_reg;
    logic [105:0]         p_reg;
    logic [2:0]           midx_reg;
    logic signed [12:0]   be_reg;
    logic                 stk_reg;
    logic                 neg_reg;
    logic                 out_valid_reg;
    logic [63:0]          value_reg;
    logic [1:0]           status_reg;

    assign out_valid  = out_valid_reg;
    assign value_bits = value_reg;
    assign status     = status_reg;

    // Take a job only when the result slot is free
    assign q_pop = (state_reg == S_IDLE) && !q_empty && !out_valid_reg;

    // 27x27 partial products of the 53x53 significand product
    logic [26:0]  op_a, op_b;
    logic [1:0]   acc_sel;
    logic [6:0]   acc_sh;
    always_comb
    begin
        case (midx_reg[1:0])
            2'd0:    begin op_a = mx_reg[26:0];        op_b = mp_reg[26:0];        end
            2'd1:    begin op_a = mx_reg[26:0];        op_b = {1'b0, mp_reg[52:27]}; end
            2'd2:    begin op_a = {1'b0, mx_reg[52:27]}; op_b = mp_reg[26:0];        end
            default: begin op_a = {1'b0, mx_reg[52:27]}; op_b = {1'b0, mp_reg[52:27]}; end
        endcase
        acc_sel = 2'(midx_reg - 3'd1);
        case (acc_sel)
            2'd0:    acc_sh = 7'd0;
            2'd3:    acc_sh = 7'd54;
            default: acc_sh = 7'd27;
        endcase
    end

    logic [105:0] prod_shifted;
    assign prod_shifted = {52'b0, prod_reg} << acc_sh;

    // Round to nearest even, then pack
    logic         rnd_up;
    logic [10:0]  fexp;
    logic [62:0]  mag;
    logic [63:0]  rnd_bits;
    always_comb
    begin
        rnd_up = p_reg[52] && ((|p_reg[51:0]) || stk_reg || p_reg[53]);
        fexp   = p_reg[105] ? be_reg[10:0] : 11'd0;
        mag    = {fexp, p_reg[104:53]} + 63'(rnd_up);
        if (be_reg >= 13'sd2047)
            rnd_bits = {neg_reg, 11'h7FF, 52'b0};
        else
            rnd_bits = {neg_reg, mag};
    end

    // Sequencer: normalize, multiply, normalize, denormalize, round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            midx_reg      <= '0;
        end
        else
        begin
            if (out_take && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        if ((q_data.status != dtd_pkg::ST_OK) || (q_data.acc == '0))
                        begin
                            out_valid_reg <= 1'b1;
                            value_reg     <= '0;
                            status_reg    <= q_data.status;
                        end
                        else
                        begin
                            a_reg     <= q_data.acc;
                            neg_reg   <= q_data.neg;
                            rom_reg   <= dtd_pkg::POW10_ROM[q_data.rom_idx];
                            sh_reg    <= '0;
                            state_reg <= S_ANORM;
                        end
                    end
                end
                S_ANORM:
                begin
                    if (a_reg[63:56] == 8'd0)
                    begin
                        a_reg  <= a_reg << 8;
                        sh_reg <= sh_reg + 6'd8;
                    end
                    else if (!a_reg[63])
                    begin
                        a_reg  <= a_reg << 1;
                        sh_reg <= sh_reg + 6'd1;
                    end
                    else
                    begin
                        // mantissa truncated to 53 bits
                        mx_reg <= a_reg[63:11];
                        mp_reg <= {(rom_reg[62:52] != 11'd0), rom_reg[51:0]};
                        if (rom_reg[62:52] == 11'd0)
                            be_reg <= 13'sd65 - signed'({7'b0, sh_reg});
                        else
                            be_reg <= signed'({2'b0, rom_reg[62:52]}) + 13'sd64
                                      - signed'({7'b0, sh_reg});
                        p_reg     <= '0;
                        midx_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (midx_reg != 3'd0)
                        p_reg <= p_reg + prod_shifted;
                    if (midx_reg != 3'd4)
                    begin
                        prod_reg <= op_a * op_b;
                        midx_reg <= midx_reg + 3'd1;
                    end
                    else
                    begin
                        midx_reg  <= '0;
                        state_reg <= S_PNORM;
                    end
                end
                S_PNORM:
                begin
                    if (p_reg[105:98] == 8'd0)
                    begin
                        p_reg  <= p_reg << 8;
                        be_reg <= be_reg - 13'sd8;
                    end
                    else if (!p_reg[105])
                    begin
                        p_reg  <= p_reg << 1;
                        be_reg <= be_reg - 13'sd1;
                    end
                    else
                    begin
                        stk_reg   <= 1'b0;
                        state_reg <= S_DENORM;
                    end
                end
                S_DENORM:
                begin
                    // subnormal result: shift right, keep a sticky bit
                    if (be_reg < 13'sd1)
                    begin
                        p_reg   <= p_reg >> 1;
                        stk_reg <= stk_reg | p_reg[0];
                        be_reg  <= be_reg + 13'sd1;
                    end
                    else
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        value_reg     <= rnd_bits;
                        status_reg    <= dtd_pkg::ST_OK;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != dtd_pkg::ST_OK)) |-> (value_reg == 64'd0))
        else $error("error result carries nonzero value");

    a_mul_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> mx_reg[52])
        else $error("multiplicand not normalized");

    a_round_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (p_reg[105] || (be_reg == 13'sd1)))
        else $error("product not aligned before rounding");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_take) |=> (out_valid_reg && $stable(value_reg)))
        else $error("pending result changed");
`endif

endmodule

// ===== bench/dtd_checker.sv =====
`timescale 1ns / 1ps

module dtd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    input  logic        empty,
    input  logic        pop,
    input  logic [63:0] value_bits,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [3:0] {
        P_START, P_AFTER_SIGN, P_LEAD_INT, P_LEAD_DEC, P_SIG_INT, P_SIG_DEC,
        P_INSIG_INT, P_INSIG_DEC, P_EXP_MARK, P_EXP_SIGN, P_EXP_DIG,
        P_END_CHECK, P_DONE
    } parse_phase_t;

    localparam int EXP_CAP  = 1048575;
    localparam int SCALE_HI = 524287;
    localparam int SCALE_LO = -524288;

    typedef struct {
        logic [63:0] bits;
        logic [1:0]  st;
    } double_result_t;

    // Parser copy
    parse_phase_t ph;
    logic [63:0]  mant;
    int           zero_run;
    int           sig_left;
    int           scale;
    int           expv;
    bit           exp_neg;
    bit           neg;
    bit           bad_char;

    double_result_t expected_q[$];

    assign pending = expected_q.size();

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic void clear_parser();
        ph       = P_START;
        mant     = '0;
        zero_run = 0;
        sig_left = dtd_pkg::MAX_SIG_DIGITS_DEF;
        scale    = 0;
        expv     = 0;
        exp_neg  = 0;
        neg      = 0;
        bad_char = 0;
    endfunction

    function automatic void bump_scale(input int delta);
        int s;
        s = scale + delta;
        if (s > SCALE_HI) s = SCALE_HI;
        if (s < SCALE_LO) s = SCALE_LO;
        scale = s;
    endfunction

    // Keep one significant digit; zeros are deferred until a nonzero follows
    function automatic void keep_digit(input int d);
        if (d != 0)
        begin
            while (zero_run > 0)
            begin
                mant = mant * 10;
                zero_run--;
            end
            mant = mant * 10 + 64'(d);
        end
        else
        begin
            zero_run++;
        end
        if (sig_left > 0) sig_left--;
        if (sig_left == 0)
            ph = (ph == P_SIG_INT) ? P_INSIG_INT : P_INSIG_DEC;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        bit ws, mark, dig, done;
        int d, e;
        ws   = (c == 8'h20 || c == 8'h09);
        mark = (c == "." || c == ",");
        dig  = (c >= "0" && c <= "9");
        d    = dig ? int'(c) - int'("0") : 0;
        done = 0;
        while (!done)
        begin
            case (ph)
                P_START:
                begin
                    if (ws) done = 1;
                    else if (c == "-")
                    begin
                        neg  = 1;
                        ph   = P_AFTER_SIGN;
                        done = 1;
                    end
                    else if (c == "+")
                    begin
                        ph   = P_AFTER_SIGN;
                        done = 1;
                    end
                    else ph = P_LEAD_INT;
                end
                P_AFTER_SIGN:
                begin
                    if (ws) done = 1;
                    else ph = P_LEAD_INT;
                end
                P_LEAD_INT:
                begin
                    if (c == "0") done = 1;
                    else if (mark)
                    begin
                        ph   = P_LEAD_DEC;
                        done = 1;
                    end
                    else ph = P_SIG_INT;
                end
                P_LEAD_DEC:
                begin
                    if (c == "0")
                    begin
                        bump_scale(-1);
                        done = 1;
                    end
                    else ph = P_SIG_DEC;
                end
                P_SIG_INT:
                begin
                    if (dig)
                    begin
                        keep_digit(d);
                        done = 1;
                    end
                    else if (mark)
                    begin
                        ph   = P_SIG_DEC;
                        done = 1;
                    end
                    else ph = P_EXP_MARK;
                end
                P_SIG_DEC:
                begin
                    if (dig)
                    begin
                        bump_scale(-1);
                        keep_digit(d);
                        done = 1;
                    end
                    else ph = P_EXP_MARK;
                end
                P_INSIG_INT:
                begin
                    if (dig)
                    begin
                        bump_scale(1);
                        done = 1;
                    end
                    else if (mark)
                    begin
                        ph   = P_INSIG_DEC;
                        done = 1;
                    end
                    else ph = P_EXP_MARK;
                end
                P_INSIG_DEC:
                begin
                    if (dig) done = 1;
                    else ph = P_EXP_MARK;
                end
                P_EXP_MARK:
                begin
                    if (c == "e" || c == "E")
                    begin
                        ph   = P_EXP_SIGN;
                        done = 1;
                    end
                    else ph = P_END_CHECK;
                end
                P_EXP_SIGN:
                begin
                    if (c == "-")
                    begin
                        exp_neg = 1;
                        ph      = P_EXP_DIG;
                        done    = 1;
                    end
                    else if (c == "+")
                    begin
                        ph   = P_EXP_DIG;
                        done = 1;
                    end
                    else ph = P_EXP_DIG;
                end
                P_EXP_DIG:
                begin
                    if (dig)
                    begin
                        e = expv * 10 + d;
                        expv = (expv > EXP_CAP / 10 || e > EXP_CAP) ? EXP_CAP : e;
                        done = 1;
                    end
                    else ph = P_END_CHECK;
                end
                P_END_CHECK:
                begin
                    if (!(c == 8'h00 || ws)) bad_char = 1;
                    ph   = P_DONE;
                    done = 1;
                end
                default: done = 1;
            endcase
        end
    endfunction

    // Truncate mantissa to 53 bits, scale by the power-of-ten table entry
    function automatic double_result_t compute_double();
        double_result_t r;
        int          k, len;
        logic [63:0] m, pattern;
        real         x;
        r.bits = '0;
        r.st   = dtd_pkg::ST_OK;
        if (bad_char)
        begin
            r.st = dtd_pkg::ST_SYNTAX;
            return r;
        end
        if (mant == 0) return r;
        k = exp_neg ? -expv : expv;
        k = k + scale + zero_run;
        if (k < dtd_pkg::K_MIN || k > dtd_pkg::K_MAX)
        begin
            r.st = dtd_pkg::ST_RANGE;
            return r;
        end
        m   = mant;
        len = 0;
        while (len < 64 && (m >> len) != 0) len++;
        if (len > 53) m = m >> (len - 53);
        else m = m << (53 - len);
        pattern = (m & 64'h000F_FFFF_FFFF_FFFF) | (64'(1022 + len) << 52);
        if (neg) pattern[63] = 1'b1;
        x = $bitstoreal(pattern) * $bitstoreal(dtd_pkg::POW10_ROM[k - dtd_pkg::K_MIN]);
        r.bits = $realtobits(x);
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        clear_parser();
    end

    // Input transfers feed the parser copy; the last character closes a number
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            parse_char(char_code);
            if (last_char)
            begin
                parse_char(8'h00);
                expected_q.push_back(compute_double());
                clear_parser();
            end
        end
    end

    // Result transfers are compared with the oldest expectation
    always @(posedge clk)
    begin
        double_result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result bits=%h status=%0d",
                                 value_bits, status));
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (value_bits !== exp_r.bits || status !== exp_r.st)
                    report($sformatf("got bits=%h status=%0d, want bits=%h status=%0d",
                                     value_bits, status, exp_r.bits, exp_r.st));
            end
        end
    end

endmodule

// ===== bench/tb_decimal_text_to_double_top.sv =====
`timescale 1ns / 1ps

module tb_decimal_text_to_double_top;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int NUM_ITEMS   = 1450;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  char_code;
    logic        last_char;
    logic        empty;
    logic        pop;
    logic [63:0] value_bits;
    logic [1:0]  status;

    int fail_count;
    int pending;
    int chars_sent;
    bit calm;
    int long_hold;

    byte unsigned text_q[$];

    decimal_text_to_double_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_code  (char_code),
        .last_char  (last_char),
        .empty      (empty),
        .pop        (pop),
        .value_bits (value_bits),
        .status     (status)
    );

    dtd_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_code  (char_code),
        .last_char  (last_char),
        .empty      (empty),
        .pop        (pop),
        .value_bits (value_bits),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stall bursts, one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                pop <= 1'b0;
                long_hold--;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 9);
            end
        end
    end

    // Send one character, waiting for the transfer
    task automatic send_char(input byte unsigned c, input bit fin);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        push      <= 1'b1;
        char_code <= c;
        last_char <= fin;
        do @(posedge clk); while (full);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        if (text_q.size() == 0) text_q.push_back(8'h00);
        send_text();
    endtask

    function automatic void add_digits(input int n);
        for (int i = 0; i < n; i++) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    endfunction

    function automatic void add_blanks();
        repeat ($urandom_range(0, 2))
            text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
    endfunction

    // Well-formed number with random content; optionally corrupted
    function automatic void build_number();
        int n;
        if ($urandom_range(0, 3) == 0) add_blanks();
        case ($urandom_range(0, 2))
            0: text_q.push_back("-");
            1: text_q.push_back("+");
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0) add_blanks();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) text_q.push_back("0");
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 12);
        add_digits(n);
        if ($urandom_range(0, 1))
        begin
            text_q.push_back($urandom_range(0, 1) ? "." : ",");
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) text_q.push_back("0");
            add_digits($urandom_range(0, 18));
        end
        if ($urandom_range(0, 1))
        begin
            text_q.push_back($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: text_q.push_back("-");
                1: text_q.push_back("+");
                default: ;
            endcase
            if ($urandom_range(0, 15) == 0) add_digits($urandom_range(7, 10));
            else
            begin
                n = $urandom_range(0, 340);
                if (n >= 100) text_q.push_back(8'(8'h30 + n / 100));
                if (n >= 10) text_q.push_back(8'(8'h30 + (n / 10) % 10));
                text_q.push_back(8'(8'h30 + n % 10));
            end
        end
        case ($urandom_range(0, 9))
            0:
            begin
                add_blanks();
                text_q.push_back(8'($urandom_range(0, 255)));
            end
            1: text_q.push_back(8'h00);
            2: text_q.push_back(8'($urandom_range(0, 255)));
            3: if (text_q.size() > 0) text_q[$urandom_range(0, text_q.size() - 1)] =
                   8'($urandom_range(0, 255));
            default: ;
        endcase
        if (text_q.size() == 0) text_q.push_back(8'h00);
    endfunction

    initial
    begin
        int strings_sent;
        rst_n      = 1'b0;
        push       = 1'b0;
        char_code  = '0;
        last_char  = 1'b0;
        chars_sent = 0;
        calm       = 0;
        long_hold  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: signs, marks, exponents, limits, errors, ignored tails
        send_literal("0");
        send_literal("-0");
        send_literal("");
        send_literal("+");
        send_literal("9");
        send_literal("-1.5");
        send_literal("1,25e-3");
        send_literal(" \t+ \t7E+2");
        send_literal("9007199254740993");
        send_literal("123456789012345678901234.5e-2");
        send_literal("0.000000000000000000012345678901234567");
        send_literal("1e308");
        send_literal("1.8e308");
        send_literal("1e-323");
        send_literal("2.5e-320");
        send_literal("4.9e-324");
        send_literal("1e99999999");
        send_literal("-1e-99999999");
        send_literal("1x");
        send_literal("12 junk");
        send_literal("e5");
        send_literal(".5");
        text_q = '{8'h31, 8'h00, 8'hFF, 8'h7A};
        send_text();
        text_q = '{8'h35, 8'hFF};
        send_text();

        // Random strings: mostly numbers, some raw noise
        strings_sent = 0;
        while (chars_sent < NUM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            else
                build_number();
            send_text();
            strings_sent++;
            if (strings_sent == 20) long_hold = 400;
            if (strings_sent == 50)
            begin
                push <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            if (chars_sent > NUM_ITEMS - 250) calm = 1;
        end
        push <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
